// ===== rtl/core/ipv4fd_pkg.sv =====
// Package for the IPv4 forwarding decision block: command and action codes,
// the routing result bundle and field widths. No dependencies.
package ipv4fd_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_ROUTE = 2'd0,
    CMD_LEARN_ARP  = 2'd1,
    CMD_FORWARD    = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_ROUTE_STORED  = 3'd0,
    ACT_ARP_LEARNED   = 3'd1,
    ACT_TABLE_FULL    = 3'd2,
    ACT_TIME_EXCEEDED = 3'd3,
    ACT_UNREACHABLE   = 3'd4,
    ACT_HOLD_REQUEST  = 3'd5,
    ACT_HOLD_PENDING  = 3'd6,
    ACT_FORWARD       = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUTE_SCAN,
    ST_ARP_SCAN,
    ST_LEARN_SCAN,
    ST_APPEND,
    ST_RESULT
  } state_t;

  // Token that travels down a chain of cells.
  typedef struct packed {
    logic        found;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } rt_tok_t;

  typedef struct packed {
    logic        found;
    logic [47:0] mac;
  } nc_tok_t;

  localparam int unsigned TTL_LIMIT = 1;

  // Number of output interfaces; the port field is two bits wide and is
  // passed on as given.
  localparam int unsigned PORTS = 4;

endpackage

// ===== rtl/core/ipv4fd_rt_cell.sv =====
// One route table cell: holds one route and merges its match into the
// passing lookup token. Depends on ipv4fd_pkg.
module ipv4fd_rt_cell (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [31:0]          wr_prefix,
  input  logic [31:0]          wr_mask,
  input  logic [31:0]          wr_gateway,
  input  logic [1:0]           wr_port,
  input  logic                 entry_used,
  input  logic [31:0]          dest_ip,
  input  ipv4fd_pkg::rt_tok_t  tok_in,
  output ipv4fd_pkg::rt_tok_t  tok_out
);
  import ipv4fd_pkg::*;

  logic [31:0] prefix_r;
  logic [31:0] mask_r;
  logic [31:0] gateway_r;
  logic [1:0]  port_r;
  logic        hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_r  <= wr_prefix;
      mask_r    <= wr_mask;
      gateway_r <= wr_gateway;
      port_r    <= wr_port;
    end
  end

  assign hit = entry_used && ((dest_ip & mask_r) == prefix_r);

  // A later entry wins only with a strictly larger mask.
  always_comb begin
    tok_out = tok_in;
    if (hit && (!tok_in.found || (tok_in.mask < mask_r))) begin
      tok_out.found   = 1'b1;
      tok_out.mask    = mask_r;
      tok_out.gateway = gateway_r;
      tok_out.port    = port_r;
    end
  end

endmodule

// ===== rtl/core/ipv4fd_nc_cell.sv =====
// One ARP cache cell: holds one address pair, answers lookups and takes
// learned addresses. Depends on ipv4fd_pkg.
module ipv4fd_nc_cell (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [31:0]          wr_ip,
  input  logic [47:0]          wr_mac,
  input  logic                 learn_en,
  input  logic                 entry_used,
  input  logic [31:0]          key_ip,
  input  ipv4fd_pkg::nc_tok_t  tok_in,
  output ipv4fd_pkg::nc_tok_t  tok_out
);
  import ipv4fd_pkg::*;

  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic        hit;

  assign hit = entry_used && (ip_r == key_ip);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end else if (learn_en && hit) begin
      mac_r <= wr_mac;
    end
  end

  // First matching entry wins.
  always_comb begin
    tok_out = tok_in;
    if (hit && !tok_in.found) begin
      tok_out.found = 1'b1;
      tok_out.mac   = mac_r;
    end
  end

endmodule

// ===== rtl/core/ipv4_forwarding_decision.sv =====
// Top level of the IPv4 forwarding decision block.
// Depends on ipv4fd_pkg, ipv4fd_rt_cell and ipv4fd_nc_cell.
//
// Route table and ARP cache are rows of cells; a lookup token is launched
// into cell 0 and ripples one cell per cycle through registers between cells.
// A forwarding decision walks the route chain and then the ARP chain before
// its result is registered, and passes through an append state when a pending
// entry is appended; an unreachable destination answers once the route chain
// has been walked, a route load or an expired TTL answers straight from idle,
// and an ARP learn answers once the ARP row has been walked (after an append
// state when it appends). One transaction is worked on at a time; the result
// sits in an output register and a new transaction is taken in the cycle after
// the result has left, so the block takes no new transaction while a decision
// is worked on or its result waits on a stalled output.
module ipv4_forwarding_decision #(
  parameter int ROUTE_ENTRIES = 64,
  parameter int ARP_ENTRIES   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[1:0], route_prefix[33:2], route_mask[65:34], route_gateway[97:66],
  // route_port[99:98], sender_ip[131:100], sender_mac[179:132],
  // dest_ip[211:180], ttl[219:212], zero fill to 224
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // action[2:0], out_port[4:3], hop_ip[36:5], hop_mac[84:37],
  // new_ttl[92:85], zero fill to 96
  output logic [95:0]  out_tdata
);
  import ipv4fd_pkg::*;

  localparam int RW = $clog2(ROUTE_ENTRIES + 1);
  localparam int NW = $clog2(ARP_ENTRIES + 1);

  logic [1:0]  in_cmd;
  logic [31:0] in_prefix, in_mask, in_gateway, in_sip, in_dip;
  logic [1:0]  in_port;
  logic [47:0] in_smac;
  logic [7:0]  in_ttl;

  assign in_cmd     = in_tdata[1:0];
  assign in_prefix  = in_tdata[33:2];
  assign in_mask    = in_tdata[65:34];
  assign in_gateway = in_tdata[97:66];
  assign in_port    = in_tdata[99:98];
  assign in_sip     = in_tdata[131:100];
  assign in_smac    = in_tdata[179:132];
  assign in_dip     = in_tdata[211:180];
  assign in_ttl     = in_tdata[219:212];

  state_t      state_r, state_nxt;
  logic [RW-1:0] rt_count_r, rt_count_nxt;
  logic [NW-1:0] nc_count_r, nc_count_nxt;
  logic [RW-1:0] rstep_r, rstep_nxt;
  logic [NW-1:0] nstep_r, nstep_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] dip_r, key_r, key_nxt;
  logic [47:0] mac_r;
  logic [7:0]  ttl_r;
  logic        learn_known_r, learn_known_nxt;
  rt_tok_t     rt_hold_r, rt_hold_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [1:0]  oport_r, oport_nxt;
  logic [31:0] ohop_r, ohop_nxt;
  logic [47:0] omac_r, omac_nxt;
  logic [7:0]  ottl_r, ottl_nxt;
  logic        accept;
  logic        rt_wr, nc_wr;
  logic [31:0] nc_wr_ip;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;

  // Route chain: tokens registered between cells.
  rt_tok_t rt_in  [ROUTE_ENTRIES];
  rt_tok_t rt_out [ROUTE_ENTRIES];
  rt_tok_t rt_pipe_r [ROUTE_ENTRIES];

  assign rt_wr = accept && (in_cmd == CMD_LOAD_ROUTE) &&
                 (rt_count_r < RW'(ROUTE_ENTRIES));

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_rt
    assign rt_in[g] = (g == 0) ? rt_tok_t'(0) : rt_pipe_r[(g == 0) ? 0 : g - 1];
    ipv4fd_rt_cell u_cell (
      .clk       (clk),
      .wr_en     (rt_wr && (rt_count_r == RW'(g))),
      .wr_prefix (in_prefix),
      .wr_mask   (in_mask),
      .wr_gateway(in_gateway),
      .wr_port   (in_port),
      .entry_used(RW'(g) < rt_count_r),
      .dest_ip   (dip_r),
      .tok_in    (rt_in[g]),
      .tok_out   (rt_out[g])
    );
    always_ff @(posedge clk) begin
      rt_pipe_r[g] <= rt_out[g];
    end
  end

  // ARP chain.
  nc_tok_t nc_in  [ARP_ENTRIES];
  nc_tok_t nc_out [ARP_ENTRIES];
  nc_tok_t nc_pipe_r [ARP_ENTRIES];
  logic [ARP_ENTRIES-1:0] learn_vec;

  for (genvar g = 0; g < ARP_ENTRIES; g++) begin : g_nc
    assign nc_in[g] = (g == 0) ? nc_tok_t'(0) : nc_pipe_r[(g == 0) ? 0 : g - 1];
    // Learning walks the row one cell per cycle, like a lookup.
    assign learn_vec[g] = (state_r == ST_LEARN_SCAN) && (nstep_r == NW'(g));
    ipv4fd_nc_cell u_cell (
      .clk       (clk),
      .wr_en     (nc_wr && (nc_count_r == NW'(g))),
      .wr_ip     (nc_wr_ip),
      .wr_mac    (mac_r),
      .learn_en  (learn_vec[g]),
      .entry_used(NW'(g) < nc_count_r),
      .key_ip    (key_r),
      .tok_in    (nc_in[g]),
      .tok_out   (nc_out[g])
    );
    always_ff @(posedge clk) begin
      nc_pipe_r[g] <= nc_out[g];
    end
  end

  // Match of the cell under the learning pointer, taken from its token output:
  // by the time the pointer reaches the first matching cell, the token coming
  // into it is empty, so found is set only by its own hit.
  logic [ARP_ENTRIES-1:0] learn_hit;
  for (genvar g = 0; g < ARP_ENTRIES; g++) begin : g_probe
    assign learn_hit[g] = nc_out[g].found && !nc_in[g].found;
  end

  // Appends happen in ST_APPEND: a learned address or a pending gateway.
  assign nc_wr    = (state_r == ST_APPEND) && (nc_count_r < NW'(ARP_ENTRIES));
  assign nc_wr_ip = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rt_count_r    <= '0;
      nc_count_r    <= '0;
      ovalid_r      <= 1'b0;
      rstep_r       <= '0;
      nstep_r       <= '0;
      learn_known_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rt_count_r    <= rt_count_nxt;
      nc_count_r    <= nc_count_nxt;
      ovalid_r      <= ovalid_nxt;
      rstep_r       <= rstep_nxt;
      nstep_r       <= nstep_nxt;
      learn_known_r <= learn_known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      dip_r <= in_dip;
      ttl_r <= in_ttl;
      mac_r <= (in_cmd == CMD_LEARN_ARP) ? in_smac : 48'd0;
    end
    key_r     <= key_nxt;
    rt_hold_r <= rt_hold_nxt;
    act_r     <= act_nxt;
    oport_r   <= oport_nxt;
    ohop_r    <= ohop_nxt;
    omac_r    <= omac_nxt;
    ottl_r    <= ottl_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    rt_count_nxt    = rt_count_r;
    nc_count_nxt    = nc_count_r;
    ovalid_nxt      = ovalid_r;
    rstep_nxt       = rstep_r;
    nstep_nxt       = nstep_r;
    learn_known_nxt = learn_known_r;
    key_nxt         = key_r;
    rt_hold_nxt     = rt_hold_r;
    act_nxt         = act_r;
    oport_nxt       = oport_r;
    ohop_nxt        = ohop_r;
    omac_nxt        = omac_r;
    ottl_nxt        = ottl_r;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = ACT_TABLE_FULL;
          oport_nxt = '0;
          ohop_nxt  = '0;
          omac_nxt  = '0;
          ottl_nxt  = '0;
          case (in_cmd)
            CMD_LOAD_ROUTE: begin
              if (rt_wr) begin
                rt_count_nxt = rt_count_r + RW'(1);
                act_nxt      = ACT_ROUTE_STORED;
              end
              ovalid_nxt = 1'b1;
            end
            CMD_LEARN_ARP: begin
              key_nxt         = in_sip;
              learn_known_nxt = 1'b0;
              nstep_nxt       = '0;
              state_nxt       = ST_LEARN_SCAN;
            end
            CMD_FORWARD: begin
              if (in_ttl <= 8'(TTL_LIMIT)) begin
                act_nxt    = ACT_TIME_EXCEEDED;
                ovalid_nxt = 1'b1;
              end else begin
                rstep_nxt = '0;
                state_nxt = ST_ROUTE_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROUTE_SCAN: begin
        // The result is taken from the last cell's register when the step count reaches ROUTE_ENTRIES.
        rstep_nxt = rstep_r + RW'(1);
        if (rstep_r == RW'(ROUTE_ENTRIES)) begin
          rt_hold_nxt = rt_pipe_r[ROUTE_ENTRIES-1];
          if (!rt_pipe_r[ROUTE_ENTRIES-1].found) begin
            act_nxt    = ACT_UNREACHABLE;
            ovalid_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            key_nxt   = rt_pipe_r[ROUTE_ENTRIES-1].gateway;
            nstep_nxt = '0;
            state_nxt = ST_ARP_SCAN;
          end
        end
      end
      ST_ARP_SCAN: begin
        nstep_nxt = nstep_r + NW'(1);
        if (nstep_r == NW'(ARP_ENTRIES)) begin
          oport_nxt = rt_hold_r.port;
          ohop_nxt  = rt_hold_r.gateway;
          if (nc_pipe_r[ARP_ENTRIES-1].found) begin
            if (nc_pipe_r[ARP_ENTRIES-1].mac == 48'd0) begin
              act_nxt = ACT_HOLD_PENDING;
            end else begin
              act_nxt  = ACT_FORWARD;
              omac_nxt = nc_pipe_r[ARP_ENTRIES-1].mac;
              ottl_nxt = ttl_r - 8'd1;
            end
            ovalid_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_LEARN_SCAN: begin
        if (|(learn_hit & learn_vec)) begin
          learn_known_nxt = 1'b1;
        end
        nstep_nxt = nstep_r + NW'(1);
        if (nstep_r == NW'(ARP_ENTRIES - 1)) begin
          if (learn_known_nxt) begin
            act_nxt    = ACT_ARP_LEARNED;
            ovalid_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        if (nc_wr) begin
          nc_count_nxt = nc_count_r + NW'(1);
          act_nxt      = (cmd_r == CMD_LEARN_ARP) ? ACT_ARP_LEARNED : ACT_HOLD_REQUEST;
        end else begin
          act_nxt = ACT_TABLE_FULL;
        end
        ovalid_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'd0, ottl_r, omac_r, ohop_r, oport_r, act_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rt_count_r <= RW'(ROUTE_ENTRIES)) && (nc_count_r <= NW'(ARP_ENTRIES)))
    else $error("table count beyond depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE) && !ovalid_r)
    else $error("input taken while busy");
  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && act_r == ACT_FORWARD) |-> (ottl_r != 8'd0))
    else $error("forward with zero ttl");
`endif

endmodule
